[src/window_moment_features_defines.svh]
// Assertion macros shared by the window moment feature block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WINDOW_MOMENT_FEATURES_DEFINES_SVH
`define WINDOW_MOMENT_FEATURES_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define WMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define WMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wmf_pkg.sv]
// Shared types and constants of the window moment feature block.
// Used by the controller, the datapath and the top level; depends on nothing.
package wmf_pkg;

	// Field widths of the item interfaces.
	localparam int PIX_W    = 8;
	localparam int CFG_W    = 9;
	localparam int CFG_RESET = 9;
	localparam int MEAN_W   = 16;
	localparam int ENERGY_W = 24;
	localparam int VAR_W    = 22;
	localparam int SKEW_W   = 17;
	localparam int KURT_W   = 20;

	// Fraction shifts applied to quotient numerators.
	localparam int MV_SH   = 8;
	localparam int SKEW_SH = 20;
	localparam int KURT_SH = 12;

	// Saturation limits.
	localparam int SKEW_POS_MAX = 65535;
	localparam int SKEW_NEG_MAX = 65536;
	localparam int KURT_MAX     = 1048575;

	// Which quotient the shared divider is working on.
	typedef enum logic [2:0] {
		JOB_MEAN,
		JOB_ENERGY,
		JOB_VAR,
		JOB_SKEW,
		JOB_KURT
	} div_job_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     prep;
		logic     diff;
		logic     sqrt_step;
		logic     pass_step;
		logic     nm;
		logic     mul_start;
		logic     mul_sel;
		logic     div_start;
		logic     div_take;
		div_job_t div_job;
		logic     finish;
	} wmf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_pixel;
		logic flat;
		logic sqrt_done;
		logic pass_done;
		logic pipe_empty;
		logic mul_done;
		logic div_done;
	} wmf_stat_t;

endpackage

[src/wmf_div.sv]
// Restoring divider, one quotient bit per cycle, for W-bit quotients.
// Self-contained; used by the datapath for all rounded quotients.
module wmf_div #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [W-1:0] quo,
	output logic         done
);

	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    work_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [W:0]      remt;
	logic [W:0]      rem_nx;
	logic            ge;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		remt   = {rem_q, work_q[W-1]};
		ge     = remt >= {1'b0, den_q};
		rem_nx = ge ? (remt - {1'b0, den_q}) : remt;
	end

	// The numerator shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (run_q) begin
			work_q <= {work_q[W-2:0], ge};
			rem_q  <= rem_nx[W-1:0];
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quo  = work_q;
	assign done = done_q;

endmodule

[src/wmf_datapath.sv]
// Datapath of the window moment feature block: accumulators, pixel store,
// square root, moment pipeline, shift-add multiplier and the shared divider.
// Depends on wmf_pkg and wmf_div.
module wmf_datapath #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wmf_pkg::wmf_cmd_t                 cmd,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   need,
	input  logic [wmf_pkg::PIX_W-1:0]         pixel,
	output wmf_pkg::wmf_stat_t                stat,
	output logic [wmf_pkg::MEAN_W-1:0]        mean_value,
	output logic [wmf_pkg::ENERGY_W-1:0]      energy,
	output logic [wmf_pkg::VAR_W-1:0]         variance,
	output logic [wmf_pkg::SKEW_W-1:0]        skewness,
	output logic [wmf_pkg::KURT_W-1:0]        kurtosis,
	output logic                              flat_window
);

	import wmf_pkg::*;

	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int DW   = PIX_W + CW;
	localparam int SW   = DW;
	localparam int QW   = 2 * PIX_W + CW;
	localparam int MW   = 2 * DW;
	localparam int RW   = DW + 8;
	localparam int NMW  = CW + MW;
	localparam int PW   = NMW + MW;
	localparam int T3W  = 3 * DW + CW;
	localparam int T4W  = 4 * DW + CW;
	localparam int DVW  = T4W + KURT_SH + 2;
	localparam int SQCW = $clog2(RW + 1);
	localparam int MCW  = $clog2(MW + 1);

	// Window accumulators.
	logic [CW-1:0]      count_q;
	logic [SW-1:0]      sum_q;
	logic [QW-1:0]      sq_q;
	logic [2*PIX_W-1:0] pix_sq;

	// Pixel store.
	logic [PIX_W-1:0] store_mem [WINDOW_MAX];
	logic [PIX_W-1:0] rd_s1;

	// Second-order terms.
	logic [MW-1:0]   nq_q;
	logic [MW-1:0]   ss_q;
	logic [2*CW-1:0] n2_q;
	logic [MW-1:0]   m_q;
	logic [MW-1:0]   m_nx;

	// Square root.
	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [SQCW-1:0] sq_cnt_q;
	logic [RW+2:0]   sq_remt;
	logic [RW+2:0]   sq_trial;
	logic [RW+2:0]   sq_rem_nx;
	logic            sq_ge;

	// Moment pipeline.
	logic [CW-1:0]   idx_q;
	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DW-1:0]   np;
	logic [DW-1:0]   d_s2, d_s3;
	logic            neg_s2, neg_s3, neg_s4;
	logic            nz_s2, nz_s3, nz_s4;
	logic [2*DW-1:0] d2_s3;
	logic [3*DW-1:0] d3_s4;
	logic [4*DW-1:0] d4_s4;
	logic [T3W:0]    t3_q;
	logic [T4W-1:0]  t4_q;
	logic [T3W-1:0]  mag;

	// Shift-add multiplier for the two denominators.
	logic [NMW-1:0] nm_q;
	logic [PW-1:0]  mcand_q;
	logic [MW-1:0]  mplier_q;
	logic [PW-1:0]  prod_q;
	logic [PW-1:0]  prod_nx;
	logic [MCW-1:0] mcnt_q;
	logic           mul_run_q;
	logic           mul_done_q;
	logic           mul_tgt_q;
	logic [PW-1:0]  den_s_q;
	logic [PW-1:0]  den_k_q;

	// Divider operands and results.
	logic [DVW-1:0]      num_j, den_j, dnum, dden, quo;
	logic                div_done;
	logic [SKEW_W-1:0]   skew_mag;
	logic [MEAN_W-1:0]   mean_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [VAR_W-1:0]    var_q;
	logic [SKEW_W-1:0]   skew_q;
	logic [KURT_W-1:0]   kurt_q;

	assign pix_sq = (2*PIX_W)'(pixel) * (2*PIX_W)'(pixel);

	// Running count, sum and sum of squares of the current window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cmd.finish) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cmd.load) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + SW'(pixel);
			sq_q    <= sq_q + QW'(pix_sq);
		end
	end

	// Store writes on load, registered reads during the moment pass.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			store_mem[count_q[AW-1:0]] <= pixel;
		end
		if (cmd.pass_step) begin
			rd_s1 <= store_mem[idx_q[AW-1:0]];
		end
	end

	assign m_nx = nq_q - ss_q;

	// Products n*Q, S*S and n*n, then M = n*Q - S*S.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			nq_q <= MW'(count_q) * MW'(sq_q);
			ss_q <= MW'(sum_q) * MW'(sum_q);
			n2_q <= (2*CW)'(count_q) * (2*CW)'(count_q);
		end
		if (cmd.diff) begin
			m_q <= m_nx;
		end
		if (cmd.nm) begin
			nm_q <= NMW'(count_q) * NMW'(m_q);
		end
	end

	// Digit-by-digit square root of M * 2^16, one root bit per step.
	always_comb begin
		sq_remt   = {rem_q, rad_q[2*RW-1 -: 2]};
		sq_trial  = {1'b0, root_q, 2'b01};
		sq_ge     = sq_remt >= sq_trial;
		sq_rem_nx = sq_ge ? (sq_remt - sq_trial) : sq_remt;
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			rad_q  <= {m_nx, 16'b0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= sq_rem_nx[RW:0];
			root_q <= {root_q[RW-2:0], sq_ge};
		end
	end

	// Square root step counter and pass read index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
			idx_q    <= '0;
		end else if (cmd.diff) begin
			sq_cnt_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.sqrt_step) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (cmd.pass_step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= cmd.pass_step;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign np = DW'(count_q) * DW'(rd_s1);

	// Deviation d = |n*p - S|, then d^2, then d^3 and d^4.
	always_ff @(posedge clk) begin
		if (np >= DW'(sum_q)) begin
			d_s2   <= np - DW'(sum_q);
			neg_s2 <= 1'b0;
		end else begin
			d_s2   <= DW'(sum_q) - np;
			neg_s2 <= 1'b1;
		end
		nz_s2  <= rd_s1 != '0;
		d2_s3  <= (2*DW)'(d_s2) * (2*DW)'(d_s2);
		d_s3   <= d_s2;
		neg_s3 <= neg_s2;
		nz_s3  <= nz_s2;
		d3_s4  <= (3*DW)'(d2_s3) * (3*DW)'(d_s3);
		d4_s4  <= (4*DW)'(d2_s3) * (4*DW)'(d2_s3);
		neg_s4 <= neg_s3;
		nz_s4  <= nz_s3;
	end

	// Signed third-moment and fourth-moment sums over nonzero pixels.
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			t3_q <= '0;
			t4_q <= '0;
		end else if (vld_s4 && nz_s4) begin
			if (neg_s4) begin
				t3_q <= t3_q - (T3W+1)'(d3_s4);
			end else begin
				t3_q <= t3_q + (T3W+1)'(d3_s4);
			end
			t4_q <= t4_q + T4W'(d4_s4);
		end
	end

	assign mag = t3_q[T3W] ? T3W'(-t3_q) : t3_q[T3W-1:0];

	// Shift-add multiply of n*M by the root or by M, one multiplier bit a cycle.
	assign prod_nx = mplier_q[0] ? (prod_q + mcand_q) : prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mcand_q  <= PW'(nm_q);
			mplier_q <= cmd.mul_sel ? m_q : MW'(root_q);
			prod_q   <= '0;
			mul_tgt_q <= cmd.mul_sel;
		end else if (mul_run_q) begin
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MW-1:1]};
			prod_q   <= prod_nx;
			if (mcnt_q == MCW'(MW - 1)) begin
				if (mul_tgt_q) begin
					den_k_q <= prod_nx;
				end else begin
					den_s_q <= prod_nx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q     <= '0;
			mul_run_q  <= 1'b0;
			mul_done_q <= 1'b0;
		end else if (cmd.mul_start) begin
			mcnt_q     <= '0;
			mul_run_q  <= 1'b1;
			mul_done_q <= 1'b0;
		end else if (mul_run_q) begin
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q == MCW'(MW - 1)) begin
				mul_run_q  <= 1'b0;
				mul_done_q <= 1'b1;
			end
		end
	end

	// Numerator and denominator of the current quotient.
	always_comb begin
		unique case (cmd.div_job)
			JOB_MEAN: begin
				num_j = DVW'({sum_q, {MV_SH{1'b0}}});
				den_j = DVW'(count_q);
			end
			JOB_ENERGY: begin
				num_j = DVW'({sq_q, {MV_SH{1'b0}}});
				den_j = DVW'(count_q);
			end
			JOB_VAR: begin
				num_j = DVW'({m_q, {MV_SH{1'b0}}});
				den_j = DVW'(n2_q);
			end
			JOB_SKEW: begin
				num_j = DVW'({mag, {SKEW_SH{1'b0}}});
				den_j = DVW'(den_s_q);
			end
			JOB_KURT: begin
				num_j = DVW'({t4_q, {KURT_SH{1'b0}}});
				den_j = DVW'(den_k_q);
			end
			default: begin
				num_j = '0;
				den_j = '0;
			end
		endcase
		// Round to nearest, ties up: (2*num + den) / (2*den).
		dnum = {num_j[DVW-2:0], 1'b0} + den_j;
		dden = {den_j[DVW-2:0], 1'b0};
	end

	wmf_div #(.W(DVW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.quo    (quo),
		.done   (div_done)
	);

	assign skew_mag = (quo > DVW'(SKEW_NEG_MAX)) ? SKEW_W'(SKEW_NEG_MAX) : quo[SKEW_W-1:0];

	// Capture each finished quotient; the higher moments start at zero.
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			skew_q <= '0;
			kurt_q <= '0;
		end else if (cmd.div_take) begin
			unique case (cmd.div_job)
				JOB_MEAN:   mean_q   <= quo[MEAN_W-1:0];
				JOB_ENERGY: energy_q <= quo[ENERGY_W-1:0];
				JOB_VAR:    var_q    <= quo[VAR_W-1:0];
				JOB_SKEW: begin
					if (t3_q[T3W]) begin
						skew_q <= SKEW_W'(0) - skew_mag;
					end else if (quo > DVW'(SKEW_POS_MAX)) begin
						skew_q <= SKEW_W'(SKEW_POS_MAX);
					end else begin
						skew_q <= quo[SKEW_W-1:0];
					end
				end
				JOB_KURT: begin
					if (quo > DVW'(KURT_MAX)) begin
						kurt_q <= KURT_W'(KURT_MAX);
					end else begin
						kurt_q <= quo[KURT_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Status to the controller.
	always_comb begin
		stat.last_pixel = ({1'b0, count_q} + 1'b1) >= {1'b0, need};
		stat.flat       = m_q == '0;
		stat.sqrt_done  = sq_cnt_q == SQCW'(RW);
		stat.pass_done  = idx_q == count_q;
		stat.pipe_empty = !(vld_s1 || vld_s2 || vld_s3 || vld_s4);
		stat.mul_done   = mul_done_q;
		stat.div_done   = div_done;
	end

	assign mean_value  = mean_q;
	assign energy      = energy_q;
	assign variance    = var_q;
	assign skewness    = skew_q;
	assign kurtosis    = kurt_q;
	assign flat_window = stat.flat;

endmodule

[src/wmf_ctrl.sv]
// Controller state machine of the window moment feature block.
// Depends on wmf_pkg; drives the datapath through wmf_cmd_t only.
module wmf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	input  wmf_pkg::wmf_stat_t stat,
	output logic               in_ready,
	output wmf_pkg::wmf_cmd_t  cmd
);

	import wmf_pkg::*;

	typedef enum logic [11:0] {
		S_LOAD   = 12'b0000_0000_0001,
		S_PREP   = 12'b0000_0000_0010,
		S_DIFF   = 12'b0000_0000_0100,
		S_SQRT   = 12'b0000_0000_1000,
		S_PASS   = 12'b0000_0001_0000,
		S_DRAIN  = 12'b0000_0010_0000,
		S_NM     = 12'b0000_0100_0000,
		S_MSTART = 12'b0000_1000_0000,
		S_MWAIT  = 12'b0001_0000_0000,
		S_DSTART = 12'b0010_0000_0000,
		S_DWAIT  = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t   state_q, state_d;
	logic     mul_sel_q, mul_sel_d;
	div_job_t job_q, job_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		mul_sel_d = mul_sel_q;
		job_d     = job_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.mul_sel = mul_sel_q;
		cmd.div_job = job_q;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.last_pixel) begin
						state_d = S_PREP;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff  = 1'b1;
				mul_sel_d = 1'b0;
				job_d     = JOB_MEAN;
				state_d   = S_SQRT;
			end
			S_SQRT: begin
				if (stat.flat) begin
					state_d = S_DSTART;
				end else if (stat.sqrt_done) begin
					state_d = S_PASS;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			S_PASS: begin
				if (stat.pass_done) begin
					state_d = S_DRAIN;
				end else begin
					cmd.pass_step = 1'b1;
				end
			end
			S_DRAIN: begin
				if (stat.pipe_empty) begin
					state_d = S_NM;
				end
			end
			S_NM: begin
				cmd.nm  = 1'b1;
				state_d = S_MSTART;
			end
			S_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (stat.mul_done) begin
					if (!mul_sel_q) begin
						mul_sel_d = 1'b1;
						state_d   = S_MSTART;
					end else begin
						state_d = S_DSTART;
					end
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_DSTART;
					unique case (job_q)
						JOB_MEAN:   job_d = JOB_ENERGY;
						JOB_ENERGY: job_d = JOB_VAR;
						JOB_VAR: begin
							if (stat.flat) begin
								state_d = S_DONE;
							end else begin
								job_d = JOB_SKEW;
							end
						end
						JOB_SKEW:   job_d = JOB_KURT;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			mul_sel_q <= 1'b0;
			job_q     <= JOB_MEAN;
		end else begin
			state_q   <= state_d;
			mul_sel_q <= mul_sel_d;
			job_q     <= job_d;
		end
	end

endmodule

[src/window_moment_features.sv]
// Top level of the window moment feature block: configuration register,
// output register, controller and datapath. Depends on wmf_pkg, wmf_ctrl,
// wmf_datapath and window_moment_features_defines.svh.
//
// Usage: write window_pixels through cfg_wr_en / cfg_wr_data while idle
// (reset value 9; 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX).
// Pixels enter on in_valid / in_ready, one item per cycle while a window
// fills. The item that completes a window starts the evaluation, during
// which in_ready is low. Evaluation uses the widths
// DW = 8 + clog2(WINDOW_MAX+1), RW = DW + 8, MW = 2*DW and
// DVW = 4*DW + clog2(WINDOW_MAX+1) + 14; a flat window skips the root,
// the pass, the two products and the last two quotients.
// The shared bit-serial divider takes the largest part of the evaluation:
// five quotients of DVW bits, three for a flat window.
// The result item is held in an output register on out_valid / out_ready;
// while it waits the next window fills, and evaluation of that window
// stalls only at its very end until the register is free.
// Reset clears the counters, the sums and the controller; the register
// returns to 9 and no result is pending.
`include "window_moment_features_defines.svh"

module window_moment_features #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wmf_pkg::CFG_W-1:0]           cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wmf_pkg::PIX_W-1:0]           pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wmf_pkg::MEAN_W-1:0]          mean_value,
	output logic [wmf_pkg::ENERGY_W-1:0]        energy,
	output logic [wmf_pkg::VAR_W-1:0]           variance,
	output logic signed [wmf_pkg::SKEW_W-1:0]   skewness,
	output logic [wmf_pkg::KURT_W-1:0]          kurtosis,
	output logic                                flat_window
);

	import wmf_pkg::*;

	localparam int CW = $clog2(WINDOW_MAX + 1);

	logic [CFG_W-1:0]    cfg_q;
	logic [CW-1:0]       need;
	logic                out_free;
	wmf_cmd_t            cmd;
	wmf_stat_t           stat;
	logic [MEAN_W-1:0]   dp_mean;
	logic [ENERGY_W-1:0] dp_energy;
	logic [VAR_W-1:0]    dp_var;
	logic [SKEW_W-1:0]   dp_skew;
	logic [KURT_W-1:0]   dp_kurt;
	logic                dp_flat;
	logic                out_valid_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [VAR_W-1:0]    var_q;
	logic [SKEW_W-1:0]   skew_q;
	logic [KURT_W-1:0]   kurt_q;
	logic                flat_q;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(CFG_RESET);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// Effective window size, clamped to one through WINDOW_MAX.
	always_comb begin
		if (cfg_q == '0) begin
			need = CW'(1);
		end else if (32'(cfg_q) > 32'(WINDOW_MAX)) begin
			need = CW'(WINDOW_MAX);
		end else begin
			need = CW'(cfg_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	wmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	wmf_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.need        (need),
		.pixel       (pixel),
		.stat        (stat),
		.mean_value  (dp_mean),
		.energy      (dp_energy),
		.variance    (dp_var),
		.skewness    (dp_skew),
		.kurtosis    (dp_kurt),
		.flat_window (dp_flat)
	);

	// Output item register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mean_q   <= dp_mean;
			energy_q <= dp_energy;
			var_q    <= dp_var;
			skew_q   <= dp_skew;
			kurt_q   <= dp_kurt;
			flat_q   <= dp_flat;
		end
	end

	assign out_valid   = out_valid_q;
	assign mean_value  = mean_q;
	assign energy      = energy_q;
	assign variance    = var_q;
	assign skewness    = skew_q;
	assign kurtosis    = kurt_q;
	assign flat_window = flat_q;

	// A new result is loaded only when the output register can take it.
	`WMF_ASSERT_IMP(a_load_when_free, cmd.finish, !out_valid_q || out_ready, "result overwrote a pending item")
	// A loaded result is shown in the next cycle.
	`WMF_ASSERT_NXT(a_finish_shows, cmd.finish, out_valid_q, "loaded result not presented")
	// A flat window carries no spread and no higher moments.
	`WMF_ASSERT_IMP(a_flat_zero, out_valid_q && flat_q, var_q == '0 && skew_q == '0 && kurt_q == '0, "flat window with nonzero moments")

endmodule
